### rtl/core/qrpix_pkg.sv
// Shared types and constants for the dual QR pixel renderer.
// Holds the class codes, register indexes, config bundle and alignment tables.
// No dependencies.
package qrpix_pkg;

    localparam int NPOS = 6;     // alignment centres along one axis, beside row/column 6

    typedef enum logic [2:0] {
        CLS_DATA      = 3'd0,
        CLS_FINDER    = 3'd1,
        CLS_ALIGN     = 3'd2,
        CLS_TIMING    = 3'd3,
        CLS_DARK      = 3'd4,
        CLS_SEPARATOR = 3'd5
    } t_class;

    typedef enum logic [1:0] {
        REG_VERSION    = 2'd0,
        REG_MODULE_PIX = 2'd1,
        REG_CENTRE     = 2'd2,
        REG_MODE       = 2'd3
    } t_reg_idx;

    // Effective configuration after clamping.
    typedef struct packed {
        logic [5:0] version;
        logic [7:0] size;
        logic [5:0] pix;
        logic [5:0] centre;
        logic       mode;
    } t_cfg;

    // Load enables of the three work stages.
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_stage_en;

    // Number of alignment coordinates per axis, including the one at 6.
    function automatic logic [2:0] align_count(input logic [5:0] v);
        logic [2:0] cnt;
        case (v) inside
            [6'd7:6'd13]:  cnt = 3'd3;
            [6'd14:6'd20]: cnt = 3'd4;
            [6'd21:6'd27]: cnt = 3'd5;
            [6'd28:6'd34]: cnt = 3'd6;
            [6'd35:6'd40]: cnt = 3'd7;
            default:       cnt = 3'd2;
        endcase
        return cnt;
    endfunction

    // Spacing between alignment centres, counted down from the last one.
    function automatic logic [4:0] align_step(input logic [5:0] v);
        logic [4:0] step;
        case (v) inside
            6'd2:                                    step = 5'd12;
            6'd3:                                    step = 5'd16;
            6'd7:                                    step = 5'd16;
            6'd8:                                    step = 5'd18;
            6'd4, 6'd9, 6'd14:                       step = 5'd20;
            6'd10, 6'd15, 6'd21:                     step = 5'd22;
            6'd5, 6'd11, 6'd16, 6'd17, 6'd22, 6'd23,
            6'd28, 6'd29, 6'd35:                     step = 5'd24;
            6'd12, 6'd18, 6'd24, 6'd25, 6'd30, 6'd31,
            6'd32, 6'd36, 6'd37, 6'd38:              step = 5'd26;
            6'd6, 6'd13, 6'd19, 6'd20, 6'd26, 6'd27,
            6'd33, 6'd34, 6'd39, 6'd40:              step = 5'd28;
            default:                                 step = 5'd0;
        endcase
        return step;
    endfunction

endpackage

### rtl/core/qrpix_cfg.sv
// Configuration registers of the pixel renderer with range clamping.
// Produces the effective version, symbol size, block size, disc size and mode.
// Depends on qrpix_pkg.
module qrpix_cfg #(
    parameter int MAX_VERSION       = 40,
    parameter int MAX_MODULE_PIXELS = 63
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [5:0]        i_cfg_data,
    output qrpix_pkg::t_cfg   o_cfg
);
    import qrpix_pkg::*;

    localparam logic [5:0] VMAX = 6'(MAX_VERSION);
    localparam logic [5:0] SMAX = 6'((MAX_MODULE_PIXELS > 63) ? 63 : MAX_MODULE_PIXELS);

    logic [5:0] r_version;
    logic [5:0] r_pix;
    logic [5:0] r_centre;
    logic       r_mode;
    logic [5:0] v_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= 6'd1;
            r_pix     <= 6'd19;
            r_centre  <= 6'd5;
            r_mode    <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_VERSION:    r_version <= i_cfg_data;
                REG_MODULE_PIX: r_pix     <= i_cfg_data;
                REG_CENTRE:     r_centre  <= i_cfg_data;
                REG_MODE:       r_mode    <= i_cfg_data[0];
                default:        r_mode    <= r_mode;
            endcase
        end
    end

    always_comb begin
        if (r_version == 6'd0) begin
            v_eff = 6'd1;
        end else if (r_version > VMAX) begin
            v_eff = VMAX;
        end else begin
            v_eff = r_version;
        end
    end

    assign o_cfg.version = v_eff;
    assign o_cfg.size    = 8'd17 + {v_eff, 2'b00};
    assign o_cfg.pix     = (r_pix > SMAX) ? SMAX : r_pix;
    assign o_cfg.centre  = r_centre;
    assign o_cfg.mode    = r_mode;

endmodule

### rtl/core/qrpix_class.sv
// Three-stage module classifier: finder, alignment, timing, dark module, separator.
// Stage 1 builds alignment centres, stage 2 tests patterns, stage 3 applies priority.
// Depends on qrpix_pkg.
module qrpix_class (
    input  logic                  i_clk,
    input  qrpix_pkg::t_stage_en  i_en,
    input  qrpix_pkg::t_cfg       i_cfg,
    input  logic [7:0]            i_row,
    input  logic [7:0]            i_col,
    output qrpix_pkg::t_class     o_class
);
    import qrpix_pkg::*;

    logic [7:0]      n_pos [NPOS];
    logic [NPOS-1:0] n_pmask;
    logic [7:0]      base;
    logic [4:0]      step;
    logic [2:0]      cnt;

    logic [7:0]      r_row1, r_col1, r_size1;
    logic [7:0]      r_pos1 [NPOS];
    logic [NPOS-1:0] r_pmask1;

    logic near_r, near_c, excl, finder, timing, dark, sep;
    logic r_finder2, r_align2, r_timing2, r_dark2, r_sep2;
    t_class n_class;
    t_class r_class3;

    // Stage 1: alignment centre coordinates for the configured version.
    always_comb begin
        base = {i_cfg.version, 2'b00} + 8'd10;
        step = align_step(i_cfg.version);
        cnt  = align_count(i_cfg.version);
        for (int i = 0; i < NPOS; i++) begin
            n_pos[i]   = base - 8'(i) * {3'b000, step};
            n_pmask[i] = (i_cfg.version >= 6'd2) && (3'(i) < (cnt - 3'd1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en1) begin
            r_row1   <= i_row;
            r_col1   <= i_col;
            r_size1  <= i_cfg.size;
            r_pos1   <= n_pos;
            r_pmask1 <= n_pmask;
        end
    end

    // Stage 2: pattern tests; mask is empty for version 1, which has no alignment.
    always_comb begin
        near_r = (|r_pmask1) && (r_row1 >= 8'd4) && (r_row1 <= 8'd8);
        near_c = (|r_pmask1) && (r_col1 >= 8'd4) && (r_col1 <= 8'd8);
        for (int i = 0; i < NPOS; i++) begin
            if (r_pmask1[i] && ({1'b0, r_row1} + 9'd2 >= {1'b0, r_pos1[i]})
                && ({1'b0, r_row1} <= {1'b0, r_pos1[i]} + 9'd2)) begin
                near_r = 1'b1;
            end
            if (r_pmask1[i] && ({1'b0, r_col1} + 9'd2 >= {1'b0, r_pos1[i]})
                && ({1'b0, r_col1} <= {1'b0, r_pos1[i]} + 9'd2)) begin
                near_c = 1'b1;
            end
        end
        finder = (r_row1 < 8'd7 && r_col1 < 8'd7)
               || (r_row1 >= r_size1 - 8'd7 && r_col1 < 8'd7)
               || (r_row1 < 8'd7 && r_col1 >= r_size1 - 8'd7);
        excl   = (r_col1 <= 8'd8 && r_row1 <= 8'd8)
               || (r_col1 <= 8'd8 && r_row1 >= r_size1 - 8'd9)
               || (r_col1 >= r_size1 - 8'd9 && r_row1 <= 8'd8);
        timing = (r_row1 == 8'd6 && r_col1 >= 8'd8 && r_col1 <= r_size1 - 8'd9)
               || (r_col1 == 8'd6 && r_row1 >= 8'd8 && r_row1 <= r_size1 - 8'd9);
        dark   = (r_row1 == r_size1 - 8'd8) && (r_col1 == 8'd8);
        sep    = (r_row1 == 8'd7 && (r_col1 < 8'd8 || r_col1 > r_size1 - 8'd9))
               || (r_row1 == r_size1 - 8'd8 && r_col1 < 8'd8)
               || (r_col1 == 8'd7 && (r_row1 < 8'd8 || r_row1 > r_size1 - 8'd9))
               || (r_col1 == r_size1 - 8'd8 && r_row1 < 8'd8);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_finder2 <= finder;
            r_align2  <= !excl && near_r && near_c;
            r_timing2 <= timing;
            r_dark2   <= dark;
            r_sep2    <= sep;
        end
    end

    // Stage 3: first matching pattern wins.
    always_comb begin
        if (r_finder2) begin
            n_class = CLS_FINDER;
        end else if (r_align2) begin
            n_class = CLS_ALIGN;
        end else if (r_timing2) begin
            n_class = CLS_TIMING;
        end else if (r_dark2) begin
            n_class = CLS_DARK;
        end else if (r_sep2) begin
            n_class = CLS_SEPARATOR;
        end else begin
            n_class = CLS_DATA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en3) begin
            r_class3 <= n_class;
        end
    end

    assign o_class = r_class3;

endmodule

### rtl/core/qrpix_disc.sv
// Three-stage centred disc test for mixed data modules.
// Offsets from the block centre, then squares, then the radius compare.
// Depends on qrpix_pkg.
module qrpix_disc (
    input  logic                  i_clk,
    input  qrpix_pkg::t_stage_en  i_en,
    input  qrpix_pkg::t_cfg       i_cfg,
    input  logic [5:0]            i_sub_row,
    input  logic [5:0]            i_sub_col,
    output logic                  o_inside
);
    import qrpix_pkg::*;

    logic [7:0]  dm, dn;
    logic [6:0]  r_am1, r_an1;
    logic [5:0]  r_c1;
    logic [13:0] r_sqm2, r_sqn2;
    logic [11:0] r_csq2;
    logic        r_inside3;

    // Offsets 2m-(s-1) stay within -62..127, so eight bits hold them.
    always_comb begin
        dm = {1'b0, i_sub_row, 1'b0} - {2'b00, i_cfg.pix} + 8'd1;
        dn = {1'b0, i_sub_col, 1'b0} - {2'b00, i_cfg.pix} + 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en1) begin
            r_am1 <= dm[7] ? 7'(-dm) : dm[6:0];
            r_an1 <= dn[7] ? 7'(-dn) : dn[6:0];
            r_c1  <= i_cfg.centre;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_sqm2 <= {7'd0, r_am1} * {7'd0, r_am1};
            r_sqn2 <= {7'd0, r_an1} * {7'd0, r_an1};
            r_csq2 <= {6'd0, r_c1} * {6'd0, r_c1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en3) begin
            r_inside3 <= ({1'b0, r_sqm2} + {1'b0, r_sqn2}) <= {3'b000, r_csq2};
        end
    end

    assign o_inside = r_inside3;

endmodule

### rtl/core/dual_qr_module_pixel_render.sv
// Top level of the dual QR pixel renderer: stream ports, stage control, pixel select.
// Depends on qrpix_pkg, qrpix_cfg, qrpix_class and qrpix_disc.
//
// Channel   | Direction | Handshake                     | Contents
// ----------+-----------+-------------------------------+-------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready | one pixel request (32 bit)
// m_axis    | out       | m_axis_tvalid / m_axis_tready | pixel color and class (8 bit)
// cfg       | in        | i_cfg_we                      | index 2 bit, data 6 bit
//
// One request per cycle while the output is not stalled; a result passes four registers
// (three work stages plus the output register) before it is valid on m_axis. Each stage
// has its own valid bit and loads when empty or when the stage after it moves, so
// bubbles close up and a stalled output holds the pipe without loss. Reset is
// synchronous and empties all stages; configuration returns to version 1, 19-pixel
// blocks, 5-pixel disc, dual mode.
module dual_qr_module_pixel_render #(
    parameter int MAX_VERSION       = 40,
    parameter int MAX_MODULE_PIXELS = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] module_row, [15:8] module_col, [21:16] sub_row, [27:22] sub_col,
    // [28] near_bit, [29] far_bit, [30] secret_white, [31] zero
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] pixel_white, [3:1] module_class, [7:4] zero
    output logic [7:0]  m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data
);
    import qrpix_pkg::*;

    t_cfg      cfg;
    t_stage_en en;
    t_class    cls3;
    logic      inside3;
    logic      rdy1, rdy2, rdy3, rdy4;
    logic      r_vld1, r_vld2, r_vld3, r_out_vld;
    logic [2:0] r_bits1, r_bits2, r_bits3;   // {secret, far, near}
    logic      n_white;
    logic      r_out_white;
    t_class    r_out_class;

    assign rdy4 = !r_out_vld || m_axis_tready;
    assign rdy3 = !r_vld3 || rdy4;
    assign rdy2 = !r_vld2 || rdy3;
    assign rdy1 = !r_vld1 || rdy2;

    assign en.en1 = rdy1;
    assign en.en2 = rdy2;
    assign en.en3 = rdy3;

    assign s_axis_tready = rdy1;

    qrpix_cfg #(
        .MAX_VERSION       (MAX_VERSION),
        .MAX_MODULE_PIXELS (MAX_MODULE_PIXELS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    qrpix_class u_class (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_cfg   (cfg),
        .i_row   (s_axis_tdata[7:0]),
        .i_col   (s_axis_tdata[15:8]),
        .o_class (cls3)
    );

    qrpix_disc u_disc (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_cfg     (cfg),
        .i_sub_row (s_axis_tdata[21:16]),
        .i_sub_col (s_axis_tdata[27:22]),
        .o_inside  (inside3)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1    <= 1'b0;
            r_vld2    <= 1'b0;
            r_vld3    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (rdy1) r_vld1    <= s_axis_tvalid;
            if (rdy2) r_vld2    <= r_vld1;
            if (rdy3) r_vld3    <= r_vld2;
            if (rdy4) r_out_vld <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) r_bits1 <= s_axis_tdata[30:28];
        if (rdy2) r_bits2 <= r_bits1;
        if (rdy3) r_bits3 <= r_bits2;
    end

    // Share mode: far bit, inverted on data modules under a black secret pixel.
    // Dual mode: function modules show near; data modules show near inside the disc, far outside.
    always_comb begin
        if (cfg.mode) begin
            n_white = !r_bits3[1] ^ ((cls3 == CLS_DATA) && !r_bits3[2]);
        end else if (cls3 != CLS_DATA) begin
            n_white = !r_bits3[0];
        end else if (inside3) begin
            n_white = !r_bits3[0];
        end else begin
            n_white = !r_bits3[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_out_white <= n_white;
            r_out_class <= cls3;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'b0000, r_out_class, r_out_white};

    // Input stalls only when every stage is full and the output is held.
    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_vld1 && r_vld2 && r_vld3 && r_out_vld && !m_axis_tready))
        else $error("input stalled with room in the pipeline");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_vld1)
        else $error("accepted request not captured in stage 1");

    a_stage3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld3 && !rdy4) |=> (r_vld3 && $stable(cls3) && $stable(inside3)
                               && $stable(r_bits3)))
        else $error("stage 3 changed while the output was stalled");

endmodule
